### design/mf3_pkg.sv
// Shared types and constants of the 3x3 median image filter.
// Used by the top level, the median pipeline and the checker; depends on nothing.
package mf3_pkg;

  localparam int DEF_MAX_WIDTH    = 4096;
  localparam int DEF_MAX_CHANNELS = 4;

  localparam int SAMPLE_W   = 8;
  localparam int IMG_W_W    = 13;
  localparam int CH_CNT_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } cfg_reg_t;

  // line stage: holding an item for its main job, or walking the right-edge run
  typedef enum logic [1:0] {
    S1_IDLE,
    S1_MAIN,
    S1_EDGE
  } line_state_t;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t upper;
    sample_t center;
    sample_t lower;
  } column_t;

  // three neighbor columns of one output sample plus its flags
  typedef struct packed {
    column_t left;
    column_t mid;
    column_t right;
    logic    row_end;
    logic    last_of_run;
  } job_t;

endpackage

### design/median_3x3_image_filter_unit.sv
// Top level of the streaming 3x3 median image filter: line buffers, window lanes, control.
// Depends on mf3_pkg, mf3_ram (two line buffers) and mf3_median (median network).
//
//   channel | beat fields (low bit first)            | handshake
//   --------+----------------------------------------+---------------------------
//   s_      | tdata: sample[7:0]; tuser: past_bottom | s_tvalid / s_tready
//   m_      | tdata: median[7:0]; tuser: row_end;    | m_tvalid / m_tready
//           | tlast: last_of_run                     |
//   cfg_    | index 0 image_width, 1 channel_count   | cfg_write, no wait
//
// One input beat per cycle inside a row unless a stall or a config write holds it off; the
// last beat of an output row holds the line stage while the channel_count right-edge
// results go out, one per cycle unless stalled. A result passes the line RAM read and
// three median stages. Each config write holds s_tready low while a bit-serial divider
// recomputes the channel index of the row position.
// Reset is synchronous; line buffers need no clearing. m_tready low backs up through the
// median stages into the line stage and then s_tready.
module median_3x3_image_filter_unit #(
  parameter int MAX_WIDTH    = mf3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = mf3_pkg::DEF_MAX_CHANNELS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mf3_pkg::SAMPLE_W-1:0]   s_tdata,    // sample
  input  logic                           s_tuser,    // past_bottom
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mf3_pkg::SAMPLE_W-1:0]   m_tdata,    // median
  output logic                           m_tuser,    // row_end
  output logic                           m_tlast,
  input  logic                           cfg_write,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IMG_W_W    = mf3_pkg::IMG_W_W;
  localparam int CH_CNT_W   = mf3_pkg::CH_CNT_W;
  localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int POS_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int TOT_W      = $clog2(LINE_DEPTH + 1);
  localparam int WC_W       = $clog2(MAX_WIDTH + 1);
  localparam int CC_W       = $clog2(MAX_CHANNELS + 1);
  localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DCNT_W     = $clog2(POS_W + 1);

  // configuration
  logic [IMG_W_W-1:0]  image_width;
  logic [CH_CNT_W-1:0] channel_count;
  logic [WC_W-1:0]     width_eff;
  logic [CC_W-1:0]     ch_eff;
  logic [CH_W-1:0]     ch_m1;
  logic [TOT_W-1:0]    total;
  logic [TOT_W-1:0]    total_m1;

  // row position
  logic [POS_W-1:0]    pos;
  logic [CH_W-1:0]     chan;
  logic                row_phase;
  logic                sat;
  logic [POS_W-1:0]    eff_pos;
  logic [CH_W-1:0]     eff_chan;
  logic                at_last;
  logic                at_first_col;
  logic                accept;

  // channel index divider
  logic                div_active;
  logic [DCNT_W-1:0]   div_cnt;
  logic [POS_W-1:0]    div_bits;
  logic [CC_W-1:0]     div_rem;
  logic [CC_W:0]       div_shift;
  logic [CC_W-1:0]     rem_next;

  // line stage
  mf3_pkg::line_state_t s1_state;
  mf3_pkg::line_state_t s1_state_next;
  logic [POS_W-1:0]    s1_addr;
  logic [CH_W-1:0]     s1_chan;
  logic [CH_W-1:0]     s1_k;
  logic                s1_first_col;
  logic                s1_last;
  logic                s1_phase;
  logic                s1_pad;
  mf3_pkg::sample_t    s1_smp;
  logic                s1_fwd;
  mf3_pkg::sample_t    s1_fwd_upper;
  mf3_pkg::sample_t    s1_fwd_middle;
  logic                goes_edge;
  logic                k_end;
  logic                main_fire;
  logic                edge_fire;
  logic                s1_done;
  logic                job_valid;
  logic                job_ready;
  mf3_pkg::job_t       job;

  // line buffers and window lanes
  mf3_pkg::sample_t    upper_q;
  mf3_pkg::sample_t    middle_q;
  mf3_pkg::sample_t    upper_rd;
  mf3_pkg::sample_t    middle_rd;
  mf3_pkg::sample_t    lower_val;
  mf3_pkg::sample_t    wr_upper;
  mf3_pkg::sample_t    wr_middle;
  logic                line_we;
  mf3_pkg::column_t    new_col;
  mf3_pkg::column_t    lane_p [MAX_CHANNELS];
  mf3_pkg::column_t    lane_q [MAX_CHANNELS];
  logic [CH_W-1:0]     lane_idx;
  mf3_pkg::column_t    lane_p_rd;
  mf3_pkg::column_t    lane_q_rd;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= IMG_W_W'(1);
      channel_count <= CH_CNT_W'(1);
    end else if (cfg_write) begin
      case (mf3_pkg::cfg_reg_t'(cfg_index))
        mf3_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[IMG_W_W-1:0];
        mf3_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[CH_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      width_eff = WC_W'(1);
    end else if ({1'b0, image_width} > (IMG_W_W + 1)'(MAX_WIDTH)) begin
      width_eff = WC_W'(MAX_WIDTH);
    end else begin
      width_eff = WC_W'(image_width);
    end
    if (channel_count == '0) begin
      ch_eff = CC_W'(1);
    end else if ({1'b0, channel_count} > (CH_CNT_W + 1)'(MAX_CHANNELS)) begin
      ch_eff = CC_W'(MAX_CHANNELS);
    end else begin
      ch_eff = CC_W'(channel_count);
    end
  end

  assign ch_m1    = CH_W'(ch_eff - CC_W'(1));
  assign total    = TOT_W'(width_eff * ch_eff);
  assign total_m1 = total - TOT_W'(1);

  // ---------------------------------------------------------------- row position
  // a position left past the row by a config change reads as the row's last sample
  assign sat          = TOT_W'(pos) >= total;
  assign eff_pos      = sat ? POS_W'(total_m1) : pos;
  assign eff_chan     = sat ? ch_m1 : chan;
  assign at_last      = TOT_W'(eff_pos) == total_m1;
  assign at_first_col = TOT_W'(eff_pos) < TOT_W'(ch_eff);
  assign accept       = s_tvalid && s_tready;

  assign div_shift = {div_rem, div_bits[POS_W-1]};
  assign rem_next  = (div_shift >= {1'b0, ch_eff}) ? CC_W'(div_shift - {1'b0, ch_eff})
                                                   : CC_W'(div_shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_active <= 1'b0;
    end else if (cfg_write) begin
      div_active <= 1'b1;
      div_cnt    <= DCNT_W'(POS_W);
      div_bits   <= pos;
      div_rem    <= '0;
    end else if (div_active) begin
      div_bits <= div_bits << 1;
      div_rem  <= rem_next;
      div_cnt  <= div_cnt - DCNT_W'(1);
      if (div_cnt == DCNT_W'(1)) begin
        div_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      chan      <= '0;
      row_phase <= 1'b0;
    end else if (accept) begin
      if (at_last) begin
        pos       <= '0;
        chan      <= '0;
        row_phase <= !s_tuser;
      end else begin
        pos  <= eff_pos + POS_W'(1);
        chan <= (eff_chan == ch_m1) ? '0 : eff_chan + CH_W'(1);
      end
    end else if (div_active && !cfg_write && div_cnt == DCNT_W'(1)) begin
      chan <= CH_W'(rem_next);
    end
  end

  // ---------------------------------------------------------------- line stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr       <= eff_pos;
      s1_chan       <= eff_chan;
      s1_first_col  <= at_first_col;
      s1_last       <= at_last;
      s1_phase      <= row_phase;
      s1_pad        <= s_tuser;
      s1_smp        <= s_tdata;
      // the RAM returns old data when the write lands in the same cycle as the read
      s1_fwd        <= line_we && (s1_addr == eff_pos);
      s1_fwd_upper  <= wr_upper;
      s1_fwd_middle <= wr_middle;
    end
    if (main_fire && goes_edge) begin
      s1_k <= '0;
    end else if (edge_fire) begin
      s1_k <= s1_k + CH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_state <= mf3_pkg::S1_IDLE;
    end else begin
      s1_state <= s1_state_next;
    end
  end

  assign goes_edge = s1_phase && s1_last;
  assign k_end     = s1_k == ch_m1;

  always_comb begin
    s1_state_next = s1_state;
    job_valid     = 1'b0;
    main_fire     = 1'b0;
    edge_fire     = 1'b0;
    s1_done       = 1'b0;
    case (s1_state)
      mf3_pkg::S1_IDLE: begin
        if (accept) begin
          s1_state_next = mf3_pkg::S1_MAIN;
        end
      end
      mf3_pkg::S1_MAIN: begin
        job_valid = s1_phase && !s1_first_col;
        main_fire = !job_valid || job_ready;
        s1_done   = main_fire && !goes_edge;
        if (main_fire) begin
          if (goes_edge) begin
            s1_state_next = mf3_pkg::S1_EDGE;
          end else if (!accept) begin
            s1_state_next = mf3_pkg::S1_IDLE;
          end
        end
      end
      mf3_pkg::S1_EDGE: begin
        job_valid = 1'b1;
        edge_fire = job_ready;
        s1_done   = edge_fire && k_end;
        if (s1_done) begin
          s1_state_next = accept ? mf3_pkg::S1_MAIN : mf3_pkg::S1_IDLE;
        end
      end
      default: s1_state_next = mf3_pkg::S1_IDLE;
    endcase
  end

  assign s_tready = !div_active && (s1_state == mf3_pkg::S1_IDLE || s1_done);

  // ---------------------------------------------------------------- line buffers
  assign upper_rd  = s1_fwd ? s1_fwd_upper : upper_q;
  assign middle_rd = s1_fwd ? s1_fwd_middle : middle_q;
  assign lower_val = s1_pad ? middle_rd : s1_smp;
  // first row fills both lines (top edge replicated); later rows roll the lines up
  assign wr_upper  = s1_phase ? middle_rd : s1_smp;
  assign wr_middle = s1_phase ? lower_val : s1_smp;
  assign line_we   = main_fire && (s1_phase || !s1_pad);

  mf3_ram #(
    .WIDTH (mf3_pkg::SAMPLE_W),
    .DEPTH (LINE_DEPTH)
  ) u_upper_line (
    .clk     (clk),
    .wr_en   (line_we),
    .wr_addr (s1_addr),
    .wr_data (wr_upper),
    .rd_en   (accept),
    .rd_addr (eff_pos),
    .rd_data (upper_q)
  );

  mf3_ram #(
    .WIDTH (mf3_pkg::SAMPLE_W),
    .DEPTH (LINE_DEPTH)
  ) u_middle_line (
    .clk     (clk),
    .wr_en   (line_we),
    .wr_addr (s1_addr),
    .wr_data (wr_middle),
    .rd_en   (accept),
    .rd_addr (eff_pos),
    .rd_data (middle_q)
  );

  // ---------------------------------------------------------------- window lanes
  // each lane keeps the two newest columns of its channel
  assign new_col.upper  = upper_rd;
  assign new_col.center = middle_rd;
  assign new_col.lower  = lower_val;

  assign lane_idx  = (s1_state == mf3_pkg::S1_EDGE) ? s1_k : s1_chan;
  assign lane_p_rd = lane_p[lane_idx];
  assign lane_q_rd = lane_q[lane_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        lane_p[i] <= '0;
        lane_q[i] <= '0;
      end
    end else if (main_fire && s1_phase) begin
      lane_p[s1_chan] <= s1_first_col ? new_col : lane_q_rd;
      lane_q[s1_chan] <= new_col;
    end
  end

  always_comb begin
    job.left  = lane_p_rd;
    job.mid   = lane_q_rd;
    if (s1_state == mf3_pkg::S1_EDGE) begin
      // replicate the right edge column
      job.right       = lane_q_rd;
      job.row_end     = k_end;
      job.last_of_run = k_end;
    end else begin
      job.right       = new_col;
      job.row_end     = 1'b0;
      job.last_of_run = !s1_last;
    end
  end

  mf3_median u_median (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .median      (m_tdata),
    .row_end     (m_tuser),
    .last_of_run (m_tlast)
  );

endmodule

### design/mf3_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the two line buffers of the median filter; no package dependencies.
module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/mf3_median.sv
// Three-stage median-of-nine network with valid/ready flow control.
// Depends on mf3_pkg for the job and column types; its last stage is the output register.
module mf3_median (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  mf3_pkg::job_t     job,
  output logic              m_tvalid,
  input  logic              m_tready,
  output mf3_pkg::sample_t  median,
  output logic              row_end,
  output logic              last_of_run
);

  function automatic mf3_pkg::sample_t min2(mf3_pkg::sample_t a, mf3_pkg::sample_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic mf3_pkg::sample_t max2(mf3_pkg::sample_t a, mf3_pkg::sample_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic mf3_pkg::sample_t med3(mf3_pkg::sample_t a, mf3_pkg::sample_t b,
                                            mf3_pkg::sample_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // sorted result: lower = smallest, upper = largest
  function automatic mf3_pkg::column_t sort3(mf3_pkg::column_t col);
    mf3_pkg::sample_t lo01;
    mf3_pkg::sample_t hi01;
    mf3_pkg::sample_t rest;
    mf3_pkg::column_t res;
    lo01       = min2(col.upper, col.center);
    hi01       = max2(col.upper, col.center);
    res.lower  = min2(lo01, col.lower);
    rest       = max2(lo01, col.lower);
    res.center = min2(hi01, rest);
    res.upper  = max2(hi01, rest);
    return res;
  endfunction

  logic             v1;
  logic             v2;
  logic             v3;
  logic             r1;
  logic             r2;
  logic             r3;
  mf3_pkg::column_t sort_l;
  mf3_pkg::column_t sort_m;
  mf3_pkg::column_t sort_r;
  logic             row_end1;
  logic             last1;
  mf3_pkg::sample_t lo_max;
  mf3_pkg::sample_t mid_med;
  mf3_pkg::sample_t hi_min;
  logic             row_end2;
  logic             last2;

  assign r3        = !v3 || m_tready;
  assign r2        = !v2 || r3;
  assign r1        = !v1 || r2;
  assign job_ready = r1;
  assign m_tvalid  = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= job_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && job_valid) begin
      sort_l   <= sort3(job.left);
      sort_m   <= sort3(job.mid);
      sort_r   <= sort3(job.right);
      row_end1 <= job.row_end;
      last1    <= job.last_of_run;
    end
    // max of the column minima, median of the middles, min of the maxima
    if (r2 && v1) begin
      lo_max   <= max2(max2(sort_l.lower, sort_m.lower), sort_r.lower);
      mid_med  <= med3(sort_l.center, sort_m.center, sort_r.center);
      hi_min   <= min2(min2(sort_l.upper, sort_m.upper), sort_r.upper);
      row_end2 <= row_end1;
      last2    <= last1;
    end
    if (r3 && v2) begin
      median      <= med3(lo_max, mid_med, hi_min);
      row_end     <= row_end2;
      last_of_run <= last2;
    end
  end

endmodule

### design/mf3_checker.sv
// Port-level checks for the 3x3 median image filter, bound to the top level.
// Depends on mf3_pkg for widths and on the top level's port names.
module mf3_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [mf3_pkg::SAMPLE_W-1:0]   m_tdata,
  input logic                           m_tuser,
  input logic                           m_tlast,
  input logic                           cfg_write
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // the end of a row always closes the run of its input beat
  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("row end without last of run");

  // input is held off after every config write while the channel index is recomputed
  a_cfg_holds_input: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> !s_tready)
    else $error("input taken right after a config write");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result beat right after reset");

endmodule

bind median_3x3_image_filter_unit mf3_checker u_mf3_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast),
  .cfg_write (cfg_write)
);
